### hdl/mcf_pkg.sv
// shared types, constants and crc helpers for the motor command framer
package mcf_pkg;

    localparam int unsigned FRAME_LEN = 9;
    localparam int unsigned IDX_W     = 4;

    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [7:0]  SYNC_BYTE  = 8'hFF;
    localparam logic [7:0]  CMD_BYTE   = 8'h07;
    localparam logic [7:0]  PAD_BYTE   = 8'h00;
    localparam logic [7:0]  CTRL_BASE  = 8'(128 + 32 + 8);
    localparam logic [7:0]  CTRL_LEFT  = 8'd64;
    localparam logic [7:0]  CTRL_RIGHT = 8'd16;

    // byte positions within the frame
    localparam logic [IDX_W-1:0] POS_SYNC   = 4'd0;
    localparam logic [IDX_W-1:0] POS_CMD    = 4'd1;
    localparam logic [IDX_W-1:0] POS_LEFT   = 4'd2;
    localparam logic [IDX_W-1:0] POS_PAD_L  = 4'd3;
    localparam logic [IDX_W-1:0] POS_RIGHT  = 4'd4;
    localparam logic [IDX_W-1:0] POS_PAD_R  = 4'd5;
    localparam logic [IDX_W-1:0] POS_CTRL   = 4'd6;
    localparam logic [IDX_W-1:0] POS_CRC_LO = 4'd7;
    localparam logic [IDX_W-1:0] POS_CRC_HI = 4'(FRAME_LEN - 1);

    typedef logic [IDX_W-1:0] byte_idx_t;

    typedef struct packed {
        logic       right_dir;
        logic       left_dir;
        logic [7:0] right_speed;
        logic [7:0] left_speed;
    } cmd_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [15:0] crc;
    } frame_t;

    function automatic logic [7:0] ctrl_byte(input cmd_t cmd);
        logic [7:0] b;
        b = CTRL_BASE;
        if (cmd.left_dir) b = b | CTRL_LEFT;
        if (cmd.right_dir) b = b | CTRL_RIGHT;
        return b;
    endfunction

    // one byte through the reflected crc, bit by bit
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) c = (c >> 1) ^ CRC_POLY;
            else      c = c >> 1;
        end
        return c;
    endfunction

    // frame byte at a given position, for all positions ahead of the crc
    function automatic logic [7:0] frame_byte_at(input byte_idx_t pos, input cmd_t cmd);
        logic [7:0] b;
        unique case (pos)
            POS_SYNC:  b = SYNC_BYTE;
            POS_CMD:   b = CMD_BYTE;
            POS_LEFT:  b = cmd.left_speed;
            POS_PAD_L: b = PAD_BYTE;
            POS_RIGHT: b = cmd.right_speed;
            POS_PAD_R: b = PAD_BYTE;
            POS_CTRL:  b = ctrl_byte(cmd);
            default:   b = PAD_BYTE;
        endcase
        return b;
    endfunction

endpackage

### hdl/mcf_crc_pipe.sv
// six-stage crc pipeline, one covered frame byte per stage
module mcf_crc_pipe import mcf_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   in_valid,
    output logic   in_ready,
    input  cmd_t   in_cmd,
    output logic   out_valid,
    input  logic   out_ready,
    output frame_t out_frame
);

    localparam int NumStages = 6;

    logic        valid_reg [NumStages];
    cmd_t        cmd_reg   [NumStages];
    logic [15:0] crc_reg   [NumStages];
    logic [NumStages:0] stg_ready;

    assign stg_ready[NumStages] = out_ready;
    assign in_ready = stg_ready[0];

    for (genvar k = 0; k < NumStages; k++) begin : g_stage
        logic        src_valid;
        cmd_t        src_cmd;
        logic [15:0] src_crc;

        if (k == 0) begin : g_head
            assign src_valid = in_valid;
            assign src_cmd   = in_cmd;
            assign src_crc   = CRC_INIT;
        end else begin : g_body
            assign src_valid = valid_reg[k-1];
            assign src_cmd   = cmd_reg[k-1];
            assign src_crc   = crc_reg[k-1];
        end

        // a stage moves when empty or when the next one takes its beat
        assign stg_ready[k] = !valid_reg[k] || stg_ready[k+1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (stg_ready[k]) begin
                valid_reg[k] <= src_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (stg_ready[k] && src_valid) begin
                cmd_reg[k] <= src_cmd;
                crc_reg[k] <= crc_byte(src_crc, frame_byte_at(IDX_W'(k + 1), src_cmd));
            end
        end

        a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
            valid_reg[k] && !stg_ready[k+1] |=> valid_reg[k] && $stable(crc_reg[k]))
            else $error("crc stage dropped a stalled beat");

        a_reset_empty: assert property (@(posedge aclk)
            !aresetn |=> !valid_reg[k])
            else $error("crc stage not empty after reset");
    end

    assign out_valid     = valid_reg[NumStages-1];
    assign out_frame.cmd = cmd_reg[NumStages-1];
    assign out_frame.crc = crc_reg[NumStages-1];

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && !out_ready |=> out_valid && $stable(out_frame))
        else $error("pipeline output changed under stall");

endmodule

### hdl/mcf_serializer.sv
// holds one finished frame and sends it out a byte per beat
module mcf_serializer import mcf_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  frame_t     in_frame,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_frame_byte,
    output logic       m_last_byte
);

    logic      busy_reg, busy_next;
    byte_idx_t cnt_reg, cnt_next;
    frame_t    frame_reg;
    logic      load;
    logic      final_beat;

    assign final_beat = busy_reg && m_ready && (cnt_reg == POS_CRC_HI);
    // next frame loads in the cycle its predecessor's last beat leaves
    assign in_ready   = !busy_reg || final_beat;
    assign load       = in_valid && in_ready;

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (load) begin
            busy_next = 1'b1;
            cnt_next  = POS_SYNC;
        end else if (final_beat) begin
            busy_next = 1'b0;
            cnt_next  = POS_SYNC;
        end else if (busy_reg && m_ready) begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= POS_SYNC;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            frame_reg <= in_frame;
        end
    end

    always_comb begin
        unique case (cnt_reg)
            POS_CRC_LO: m_frame_byte = frame_reg.crc[7:0];
            POS_CRC_HI: m_frame_byte = frame_reg.crc[15:8];
            default:    m_frame_byte = frame_byte_at(cnt_reg, frame_reg.cmd);
        endcase
    end

    assign m_valid     = busy_reg;
    assign m_last_byte = (cnt_reg == POS_CRC_HI);

    a_stall_holds_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(cnt_reg))
        else $error("byte position moved under stall");

    a_load_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_ready && busy_reg |-> m_ready && m_last_byte)
        else $error("new frame loaded over an unfinished one");

    a_no_short_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_byte |=> m_valid)
        else $error("frame cut short");

endmodule

### hdl/motor_command_framer_crc16_top.sv
// Motor command framer: each accepted command (two wheel speeds, two direction bits) comes out
// as a nine-byte frame 0xFF 0x07 L 0x00 R 0x00 CTRL CRC_LO CRC_HI, one byte per beat, with
// m_last_byte high on the crc high byte. The crc is CRC-16/MODBUS over bytes two to seven.
// Commands pass a six-stage crc pipeline that takes one command per cycle unless stalled, then a
// byte serializer; the serializer sends one byte per cycle while m_ready stays high and starts
// the next frame right after the last byte of the one before. The first byte of a frame is
// offered once its command has passed the six crc stages and been loaded into the serializer,
// and up to seven commands can be held in flight while the result side stalls.
module motor_command_framer_crc16_top import mcf_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_left_speed,
    input  logic [7:0] s_right_speed,
    input  logic       s_left_dir,
    input  logic       s_right_dir,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_frame_byte,
    output logic       m_last_byte
);

    cmd_t   in_cmd;
    frame_t pipe_frame;
    logic   pipe_valid;
    logic   pipe_ready;

    assign in_cmd.left_speed  = s_left_speed;
    assign in_cmd.right_speed = s_right_speed;
    assign in_cmd.left_dir    = s_left_dir;
    assign in_cmd.right_dir   = s_right_dir;

    mcf_crc_pipe u_crc_pipe (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_cmd    (in_cmd),
        .out_valid (pipe_valid),
        .out_ready (pipe_ready),
        .out_frame (pipe_frame)
    );

    mcf_serializer u_serializer (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (pipe_valid),
        .in_ready     (pipe_ready),
        .in_frame     (pipe_frame),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_frame_byte (m_frame_byte),
        .m_last_byte  (m_last_byte)
    );

endmodule
